// ===== hdl/vtll_pkg.sv =====
// Shared types, widths and constants of the vector to longitude/latitude block.
package vtll_pkg;

   localparam int PT_W         = 16;
   localparam int PROD_W       = 32;
   localparam int CROSS_W      = 33;
   localparam int DOT_W        = 34;
   localparam int MAG_W        = 32;
   localparam int SQ_W         = 64;
   localparam int ROOT_W       = 32;
   localparam int ISQRT_STAGES = 32;
   localparam int CORDIC_ITER  = 30;
   localparam int CORDIC_W     = 36;
   localparam int ACC_W        = 33;
   localparam int ACC_FRAC     = 29;
   localparam int FRONT_LAT    = 4;
   localparam int CORDIC_LAT   = CORDIC_ITER + 2;
   localparam int ANGLE_LAT    = FRONT_LAT + ISQRT_STAGES + CORDIC_LAT;

   localparam logic signed [ACC_W-1:0] PI_ACC      = 33'sd1686629713;
   localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 33'sd843314856;

   localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_ITER] = '{
      33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762579, 33'sd33510843,
      33'sd16771758, 33'sd8387925, 33'sd4194219, 33'sd2097141, 33'sd1048575,
      33'sd524288, 33'sd262144, 33'sd131072, 33'sd65536, 33'sd32768,
      33'sd16384, 33'sd8192, 33'sd4096, 33'sd2048, 33'sd1024,
      33'sd512, 33'sd256, 33'sd128, 33'sd64, 33'sd32,
      33'sd16, 33'sd8, 33'sd4, 33'sd2, 33'sd1
   };

   localparam logic [1:0] REG_FRONT_X = 2'd0;
   localparam logic [1:0] REG_FRONT_Y = 2'd1;
   localparam logic [1:0] REG_FRONT_Z = 2'd2;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

// ===== hdl/vtll_isqrt.sv =====
// Pipelined floor integer square root, one result bit per stage, with a side tag.
module vtll_isqrt import vtll_pkg::*; #(
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   n_in,
   input  logic [TAG_W-1:0]  tag_in,
   output logic [ROOT_W-1:0] root,
   output logic [TAG_W-1:0]  tag_out
);

   logic [SQ_W-1:0]  rem_ff  [ISQRT_STAGES];
   logic [SQ_W-1:0]  res_ff  [ISQRT_STAGES];
   logic [TAG_W-1:0] tag_ff  [ISQRT_STAGES];
   logic [SQ_W-1:0]  rem_src [ISQRT_STAGES];
   logic [SQ_W-1:0]  res_src [ISQRT_STAGES];
   logic [TAG_W-1:0] tag_src [ISQRT_STAGES];
   logic [SQ_W-1:0]  rem_in  [ISQRT_STAGES];
   logic [SQ_W-1:0]  res_in  [ISQRT_STAGES];

   for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
      localparam logic [SQ_W-1:0] BIT = 64'd1 << (SQ_W - 2 - 2 * k);
      logic [SQ_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rem_src[k] = n_in;
         assign res_src[k] = '0;
         assign tag_src[k] = tag_in;
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign res_src[k] = res_ff[k-1];
         assign tag_src[k] = tag_ff[k-1];
      end

      always_comb begin
         trial = res_src[k] + BIT;
         if (rem_src[k] >= trial) begin
            rem_in[k] = rem_src[k] - trial;
            res_in[k] = (res_src[k] >> 1) + BIT;
         end else begin
            rem_in[k] = rem_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign root    = res_ff[ISQRT_STAGES-1][ROOT_W-1:0];
   assign tag_out = tag_ff[ISQRT_STAGES-1];

endmodule

// ===== hdl/vtll_cordic.sv =====
// Pipelined vectoring CORDIC giving the rounded angle of (dot, cross magnitude).
module vtll_cordic import vtll_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CODE_W          = 15
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [ROOT_W-1:0]        y_in,
   input  logic signed [DOT_W-1:0]  x_in,
   input  logic                     zero_in,
   output logic [CODE_W-1:0]        code
);

   localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [ACC_W:0] ROUND = (SH > 0) ? ((ACC_W + 1)'(1) << (SH - 1)) : '0;

   logic signed [CORDIC_W-1:0] x_ff   [CORDIC_ITER+1];
   logic signed [CORDIC_W-1:0] y_ff   [CORDIC_ITER+1];
   logic signed [ACC_W-1:0]    z_ff   [CORDIC_ITER+1];
   logic                       byp_ff [CORDIC_ITER+1];
   logic signed [CORDIC_W-1:0] x0_in, y0_in;
   logic signed [ACC_W-1:0]    z0_in;
   logic                       byp0_in;
   logic signed [ACC_W-1:0]    z_clamp;
   logic [ACC_W:0]             z_round;
   logic [ACC_W:0]             z_shift;
   logic [CODE_W-1:0]          code_ff;

   always_comb begin
      x0_in   = CORDIC_W'(x_in);
      y0_in   = CORDIC_W'(signed'({1'b0, y_in}));
      z0_in   = '0;
      byp0_in = 1'b0;
      if (zero_in) begin
         byp0_in = 1'b1;
      end else if (y_in == '0) begin
         byp0_in = 1'b1;
         if (x_in < 0) begin
            z0_in = PI_ACC;
         end
      end else if (x_in < 0) begin
         x0_in = CORDIC_W'(signed'({1'b0, y_in}));
         y0_in = -CORDIC_W'(x_in);
         z0_in = HALF_PI_ACC;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x0_in;
         y_ff[0]   <= y0_in;
         z_ff[0]   <= z0_in;
         byp_ff[0] <= byp0_in;
      end
   end

   for (genvar i = 0; i < CORDIC_ITER; i++) begin : g_iter
      logic signed [CORDIC_W-1:0] dx, dy, x_in_i, y_in_i;
      logic signed [ACC_W-1:0]    z_in_i;

      always_comb begin
         dx     = y_ff[i] >>> i;
         dy     = x_ff[i] >>> i;
         x_in_i = x_ff[i];
         y_in_i = y_ff[i];
         z_in_i = z_ff[i];
         if (!byp_ff[i]) begin
            if (y_ff[i] >= 0) begin
               x_in_i = x_ff[i] + dx;
               y_in_i = y_ff[i] - dy;
               z_in_i = z_ff[i] + ATAN_TAB[i];
            end else begin
               x_in_i = x_ff[i] - dx;
               y_in_i = y_ff[i] + dy;
               z_in_i = z_ff[i] - ATAN_TAB[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]   <= x_in_i;
            y_ff[i+1]   <= y_in_i;
            z_ff[i+1]   <= z_in_i;
            byp_ff[i+1] <= byp_ff[i];
         end
      end
   end

   always_comb begin
      priority if (z_ff[CORDIC_ITER] < 0) begin
         z_clamp = '0;
      end else if (z_ff[CORDIC_ITER] > PI_ACC) begin
         z_clamp = PI_ACC;
      end else begin
         z_clamp = z_ff[CORDIC_ITER];
      end
      z_round = {1'b0, z_clamp} + ROUND;
      z_shift = z_round >> SH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= z_shift[CODE_W-1:0];
      end
   end

   assign code = code_ff;

endmodule

// ===== hdl/vtll_angle.sv =====
// Angle between two 16-bit vectors: cross and dot products, square root and CORDIC.
module vtll_angle import vtll_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CODE_W          = 15
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [PT_W-1:0]  u_x,
   input  logic signed [PT_W-1:0]  u_y,
   input  logic signed [PT_W-1:0]  u_z,
   input  logic signed [PT_W-1:0]  v_x,
   input  logic signed [PT_W-1:0]  v_y,
   input  logic signed [PT_W-1:0]  v_z,
   output logic [CODE_W-1:0]       code
);

   logic signed [PROD_W-1:0]  m_yz_ff, m_zy_ff, m_zx_ff, m_xz_ff, m_xy_ff, m_yx_ff;
   logic signed [PROD_W-1:0]  d_x_ff, d_y_ff, d_z_ff;
   logic                      zero1_ff, zero2_ff, zero3_ff, zero4_ff;
   logic signed [CROSS_W-1:0] c0_ff, c1_ff, c2_ff;
   logic signed [DOT_W-1:0]   dot2_ff, dot3_ff, dot4_ff;
   logic signed [CROSS_W-1:0] c0_abs, c1_abs, c2_abs;
   logic [MAG_W-1:0]          mag0, mag1, mag2;
   logic [SQ_W-1:0]           sq0_ff, sq1_ff, sq2_ff, sum_ff;
   logic [ROOT_W-1:0]         root;
   logic [DOT_W:0]            tag_out;

   always_ff @(posedge clock) begin
      if (en) begin
         zero1_ff <= ((u_x == '0) && (u_y == '0) && (u_z == '0)) ||
                     ((v_x == '0) && (v_y == '0) && (v_z == '0));
         m_yz_ff  <= u_y * v_z;
         m_zy_ff  <= u_z * v_y;
         m_zx_ff  <= u_z * v_x;
         m_xz_ff  <= u_x * v_z;
         m_xy_ff  <= u_x * v_y;
         m_yx_ff  <= u_y * v_x;
         d_x_ff   <= u_x * v_x;
         d_y_ff   <= u_y * v_y;
         d_z_ff   <= u_z * v_z;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero2_ff <= zero1_ff;
         c0_ff    <= CROSS_W'(m_yz_ff) - CROSS_W'(m_zy_ff);
         c1_ff    <= CROSS_W'(m_zx_ff) - CROSS_W'(m_xz_ff);
         c2_ff    <= CROSS_W'(m_xy_ff) - CROSS_W'(m_yx_ff);
         dot2_ff  <= DOT_W'(d_x_ff) + DOT_W'(d_y_ff) + DOT_W'(d_z_ff);
      end
   end

   always_comb begin
      c0_abs = (c0_ff < 0) ? -c0_ff : c0_ff;
      c1_abs = (c1_ff < 0) ? -c1_ff : c1_ff;
      c2_abs = (c2_ff < 0) ? -c2_ff : c2_ff;
      mag0   = c0_abs[MAG_W-1:0];
      mag1   = c1_abs[MAG_W-1:0];
      mag2   = c2_abs[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero3_ff <= zero2_ff;
         dot3_ff  <= dot2_ff;
         sq0_ff   <= SQ_W'(mag0) * SQ_W'(mag0);
         sq1_ff   <= SQ_W'(mag1) * SQ_W'(mag1);
         sq2_ff   <= SQ_W'(mag2) * SQ_W'(mag2);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero4_ff <= zero3_ff;
         dot4_ff  <= dot3_ff;
         sum_ff   <= sq0_ff + sq1_ff + sq2_ff;
      end
   end

   vtll_isqrt #(
      .TAG_W (DOT_W + 1)
   ) u_isqrt (
      .clock   (clock),
      .en      (en),
      .n_in    (sum_ff),
      .tag_in  ({zero4_ff, dot4_ff}),
      .root    (root),
      .tag_out (tag_out)
   );

   vtll_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CODE_W          (CODE_W)
   ) u_cordic (
      .clock   (clock),
      .en      (en),
      .y_in    (root),
      .x_in    (signed'(tag_out[DOT_W-1:0])),
      .zero_in (tag_out[DOT_W]),
      .code    (code)
   );

endmodule

// ===== hdl/vector_to_lon_lat_core.sv =====
// Top level of the vector to longitude/latitude block: registers, pipeline and output.
//
// A direction vector arrives on the req_ channel; one transaction is accepted at each
// rising edge where req_valid is high and req_stall is low. Each accepted vector yields
// exactly one transaction on the rsp_ channel carrying longitude and latitude in signed
// radians with ANGLE_FRAC_BITS fraction bits, relative to the front vector held in the
// three APB registers (front_x at 0x0, front_y at 0x4, front_z at 0x8).
// The pipeline accepts one vector per cycle while the output is not held, and passes each
// result through one input stage, the angle units (products, a 32-stage square root with
// one result bit per stage, and a CORDIC with one rotation per iteration) and the
// output register. The three angle units run side by side so that latitude can be
// chosen after longitude is known without holding the stream.
// When the receiver stalls while a result is waiting, the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// A synchronous reset empties the pipeline and sets the front vector to (0, 0, 1).
// Registers should be written only while no transaction is in flight.
module vector_to_lon_lat_core import vtll_pkg::*; #(
   parameter int COMPONENT_BITS  = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [3:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COMPONENT_BITS-1:0] req_point_x,
   input  logic signed [COMPONENT_BITS-1:0] req_point_y,
   input  logic signed [COMPONENT_BITS-1:0] req_point_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [15:0]               rsp_longitude,
   output logic signed [15:0]               rsp_latitude
);

   localparam int WIDE   = (COMPONENT_BITS > PT_W) ? COMPONENT_BITS : PT_W;
   localparam int EXTRA  = WIDE - PT_W;
   localparam int CODE_W = ANGLE_FRAC_BITS + 2;
   localparam int OUT_W  = ((CODE_W > 16) ? CODE_W : 16) + 1;

   function automatic logic fits16(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] t;
      t = v >>> (PT_W - 1);
      return (t == '0) || (t == '1);
   endfunction

   function automatic logic [3*PT_W-1:0] reduce_vec(input logic signed [WIDE-1:0] a,
                                                   input logic signed [WIDE-1:0] b,
                                                   input logic signed [WIDE-1:0] c);
      logic signed [WIDE-1:0] ta, tb, tc;
      int sel;
      sel = EXTRA;
      for (int s = EXTRA; s >= 0; s--) begin
         ta = a >>> s;
         tb = b >>> s;
         tc = c >>> s;
         if (fits16(ta) && fits16(tb) && fits16(tc)) begin
            sel = s;
         end
      end
      ta = a >>> sel;
      tb = b >>> sel;
      tc = c >>> sel;
      return {ta[PT_W-1:0], tb[PT_W-1:0], tc[PT_W-1:0]};
   endfunction

   logic [COMPONENT_BITS-1:0] front_x_ff, front_y_ff, front_z_ff;
   logic                      en;
   logic [3*PT_W-1:0]         f_red, p_red;
   logic signed [PT_W-1:0]    fa_x_ff, fa_y_ff, fa_z_ff;
   logic signed [PT_W-1:0]    pa_x_ff, pa_y_ff, pa_z_ff;
   logic                      valid_a_ff;
   logic [CODE_W-1:0]         code_a, code_b, code_c, lat_code;
   side_type                  side_ff [ANGLE_LAT];
   logic signed [OUT_W-1:0]   lon_w, lat_w;
   logic                      rsp_valid_ff;
   logic signed [15:0]        rsp_longitude_ff, rsp_latitude_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_x_ff <= '0;
         front_y_ff <= '0;
         front_z_ff <= COMPONENT_BITS'(1);
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_FRONT_X: front_x_ff <= pwdata[COMPONENT_BITS-1:0];
            REG_FRONT_Y: front_y_ff <= pwdata[COMPONENT_BITS-1:0];
            REG_FRONT_Z: front_z_ff <= pwdata[COMPONENT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_FRONT_X: prdata = 32'(front_x_ff);
         REG_FRONT_Y: prdata = 32'(front_y_ff);
         REG_FRONT_Z: prdata = 32'(front_z_ff);
         default:     prdata = '0;
      endcase
   end

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   assign f_red = reduce_vec(WIDE'(signed'(front_x_ff)), WIDE'(signed'(front_y_ff)),
                             WIDE'(signed'(front_z_ff)));
   assign p_red = reduce_vec(WIDE'(req_point_x), WIDE'(req_point_y), WIDE'(req_point_z));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fa_x_ff <= signed'(f_red[3*PT_W-1:2*PT_W]);
         fa_y_ff <= signed'(f_red[2*PT_W-1:PT_W]);
         fa_z_ff <= signed'(f_red[PT_W-1:0]);
         pa_x_ff <= signed'(p_red[3*PT_W-1:2*PT_W]);
         pa_y_ff <= signed'(p_red[2*PT_W-1:PT_W]);
         pa_z_ff <= signed'(p_red[PT_W-1:0]);
      end
   end

   vtll_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CODE_W(CODE_W)) u_angle_lon (
      .clock (clock), .en (en),
      .u_x (fa_x_ff), .u_y (fa_y_ff), .u_z (fa_z_ff),
      .v_x (pa_x_ff), .v_y ('0),      .v_z (pa_z_ff),
      .code (code_a)
   );

   vtll_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CODE_W(CODE_W)) u_angle_front (
      .clock (clock), .en (en),
      .u_x (fa_x_ff), .u_y (fa_y_ff), .u_z (fa_z_ff),
      .v_x (pa_x_ff), .v_y (pa_y_ff), .v_z (pa_z_ff),
      .code (code_b)
   );

   vtll_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CODE_W(CODE_W)) u_angle_lat (
      .clock (clock), .en (en),
      .u_x (pa_x_ff), .u_y ('0),      .u_z (pa_z_ff),
      .v_x (pa_x_ff), .v_y (pa_y_ff), .v_z (pa_z_ff),
      .code (code_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ANGLE_LAT; k++) begin
            side_ff[k] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= '{valid: valid_a_ff, neg_x: pa_x_ff < 0, neg_y: pa_y_ff < 0};
         for (int k = 1; k < ANGLE_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      lat_code = (code_a == '0) ? code_b : code_c;
      lon_w    = signed'(OUT_W'(code_a));
      lat_w    = signed'(OUT_W'(lat_code));
      if (side_ff[ANGLE_LAT-1].neg_x) begin
         lon_w = -lon_w;
      end
      if (side_ff[ANGLE_LAT-1].neg_y) begin
         lat_w = -lat_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_ff[ANGLE_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_longitude_ff <= lon_w[15:0];
         rsp_latitude_ff  <= lat_w[15:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_longitude = rsp_longitude_ff;
   assign rsp_latitude  = rsp_latitude_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_a_ff)
      else $error("Accepted transaction did not enter the pipeline.");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(side_ff[ANGLE_LAT-1]) && $stable(valid_a_ff)))
      else $error("Pipeline moved while the output was stalled.");

   a_result_delivered : assert property (@(posedge clock) disable iff (reset)
      (side_ff[ANGLE_LAT-1].valid && en) |=> rsp_valid)
      else $error("Finished transaction did not reach the output register.");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for vector_to_lon_lat_core with a longitude/latitude predictor.
module tb_top import vtll_pkg::*;;

   typedef struct {
      logic signed [15:0] longitude;
      logic signed [15:0] latitude;
   } angle_pair_type;

   localparam int STALL_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic signed [15:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_longitude;
   logic signed [15:0] rsp_latitude;

   logic signed [15:0] front_vec [3];
   angle_pair_type     pending_angles [$];
   int                 mismatch_count = 0;
   int                 idle_cycles = 0;
   bit                 sender_busy_mode = 1'b0;
   bit                 receiver_busy_mode = 1'b0;
   int                 long_hold_request = 0;
   int                 hold_left = 0;

   vector_to_lon_lat_core i_dut (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_stall(req_stall), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_point_z(req_point_z), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_longitude(rsp_longitude), .rsp_latitude(rsp_latitude)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic int cordic_angle(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      longint t;
      z = 0;
      if (y == 0) begin
         z = (x >= 0) ? 0 : longint'(PI_ACC);
      end else begin
         if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(HALF_PI_ACC);
         end
         for (int i = 0; i < CORDIC_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ATAN_TAB[i]);
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ATAN_TAB[i]);
            end
         end
         if (z < 0) z = 0;
         if (z > longint'(PI_ACC)) z = longint'(PI_ACC);
      end
      z = (z + (longint'(1) << 15)) >>> 16;
      return int'(z);
   endfunction

   function automatic int angle_between(longint u0, longint u1, longint u2,
                                        longint v0, longint v1, longint v2);
      longint c0;
      longint c1;
      longint c2;
      longint dot;
      longint unsigned sq;
      if ((u0 == 0 && u1 == 0 && u2 == 0) || (v0 == 0 && v1 == 0 && v2 == 0))
         return 0;
      c0 = u1 * v2 - u2 * v1;
      c1 = u2 * v0 - u0 * v2;
      c2 = u0 * v1 - u1 * v0;
      sq = longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2);
      dot = u0 * v0 + u1 * v1 + u2 * v2;
      return cordic_angle(longint'(floor_sqrt(sq)), dot);
   endfunction

   function automatic angle_pair_type predict_lon_lat(logic signed [15:0] px,
                                                      logic signed [15:0] py,
                                                      logic signed [15:0] pz);
      angle_pair_type res;
      longint fx;
      longint fy;
      longint fz;
      int lon;
      int lat;
      fx = front_vec[0];
      fy = front_vec[1];
      fz = front_vec[2];
      lon = angle_between(fx, fy, fz, px, 0, pz);
      if (lon == 0) lat = angle_between(fx, fy, fz, px, py, pz);
      else lat = angle_between(px, 0, pz, px, py, pz);
      if (px < 0) lon = -lon;
      if (py < 0) lat = -lat;
      res.longitude = lon[15:0];
      res.latitude = lat[15:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Result checker and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      angle_pair_type want;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("unexpected result transaction", 1, 0);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_longitude !== want.longitude)
               report_mismatch("longitude", rsp_longitude, want.longitude);
            if (rsp_latitude !== want.latitude)
               report_mismatch("latitude", rsp_latitude, want.latitude);
         end
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random holds per result, runs without holds, and one long hold on request.
   always @(negedge clock) begin
      if (long_hold_request > 0) begin
         hold_left = long_hold_request;
         long_hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !receiver_busy_mode && hold_left == 0)
         hold_left = $urandom_range(0, 15);
   end

   task automatic send_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz);
      int gap;
      gap = sender_busy_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      do @(posedge clock); while (req_stall);
      pending_angles.push_back(predict_lon_lat(px, py, pz));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(negedge clock);
      repeat (ANGLE_LAT + 10) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic signed [15:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= {{16{value[15]}}, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_front(logic signed [15:0] fx, logic signed [15:0] fy,
                            logic signed [15:0] fz);
      wait_drained();
      csr_write(REG_FRONT_X, fx);
      csr_write(REG_FRONT_Y, fy);
      csr_write(REG_FRONT_Z, fz);
      front_vec[0] = fx;
      front_vec[1] = fy;
      front_vec[2] = fz;
   endtask

   function automatic logic signed [15:0] pick_component();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         3: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   task automatic send_random_points(int count);
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      for (int n = 0; n < count; n++) begin
         px = pick_component();
         py = pick_component();
         pz = pick_component();
         // Some points get a zero x or y component, so they lie in the x = 0 or y = 0 plane or on the z axis.
         if ($urandom_range(0, 7) == 0) px = 16'sd0;
         if ($urandom_range(0, 7) == 0) py = 16'sd0;
         send_point(px, py, pz);
      end
   endtask

   task automatic test_directed_reset_front();
      send_point(16'sd0, 16'sd0, 16'sd0);
      send_point(16'sd0, 16'sd0, 16'sd100);
      send_point(16'sd0, 16'sd0, -16'sd100);
      send_point(16'sd0, 16'sd5, 16'sd7);
      send_point(16'sd0, -16'sd5, -16'sd7);
      send_point(16'sd0, 16'sd9, 16'sd0);
      send_point(16'sd0, -16'sd9, 16'sd0);
      send_point(16'sd10, 16'sd0, 16'sd0);
      send_point(-16'sd10, 16'sd0, 16'sd0);
      send_point(-16'sd10, -16'sd10, -16'sd10);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh8000, 16'sh7fff, 16'sh8000);
      send_point(16'sh7fff, 16'sh8000, 16'sd1);
      send_point(16'sd1, 16'sh7fff, -16'sd1);
      send_point(-16'sd1, 16'sd1, 16'sh8000);
   endtask

   task automatic test_directed_fronts();
      set_front(16'sd0, 16'sd0, 16'sd0);
      send_point(16'sd3, 16'sd4, 16'sd5);
      send_point(16'sd0, 16'sd0, 16'sd0);
      set_front(16'sh8000, 16'sh7fff, 16'sh8000);
      send_point(16'sh8000, 16'sh7fff, 16'sh8000);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_point(-16'sd1, 16'sd1, -16'sd1);
      set_front(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_point(16'sh7fff, 16'sd0, 16'sh7fff);
      send_point(16'sd0, 16'sd50, 16'sd0);
   endtask

   task automatic test_random_fronts();
      for (int phase = 0; phase < 6; phase++) begin
         set_front(pick_component(), pick_component(), pick_component());
         sender_busy_mode = (phase % 3 == 1);
         receiver_busy_mode = (phase % 3 == 1);
         send_random_points(130);
      end
      sender_busy_mode = 1'b0;
      receiver_busy_mode = 1'b0;
   endtask

   task automatic test_back_pressure();
      set_front(16'sd0, 16'sd0, 16'sd1);
      sender_busy_mode = 1'b1;
      long_hold_request = 300;
      send_random_points(150);
      sender_busy_mode = 1'b0;
   endtask

   task automatic test_sender_pause();
      send_random_points(40);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(negedge clock);
      send_random_points(40);
   endtask

   initial begin
      front_vec[0] = 16'sd0;
      front_vec[1] = 16'sd0;
      front_vec[2] = 16'sd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_reset_front();
      test_directed_fronts();
      test_random_fronts();
      test_back_pressure();
      test_sender_pause();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== vector_to_lon_lat_core.f =====
hdl/vtll_pkg.sv
hdl/vtll_isqrt.sv
hdl/vtll_cordic.sv
hdl/vtll_angle.sv
hdl/vector_to_lon_lat_core.sv
sim/tb_top.sv
